// ----- rtl/amv_pkg.sv -----
// Shared types and constants for the affine matrix inverse block.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package amv_pkg;

  localparam logic [1:0] ROW_FIRST = 2'd0;
  localparam logic [1:0] ROW_LAST = 2'd2;

  // One request on the input channel: a 3x4 affine matrix in fixed point.
  typedef struct packed {
    logic signed [31:0] a_r0c0;
    logic signed [31:0] a_r0c1;
    logic signed [31:0] a_r0c2;
    logic signed [31:0] shift_r0;
    logic signed [31:0] a_r1c0;
    logic signed [31:0] a_r1c1;
    logic signed [31:0] a_r1c2;
    logic signed [31:0] shift_r1;
    logic signed [31:0] a_r2c0;
    logic signed [31:0] a_r2c1;
    logic signed [31:0] a_r2c2;
    logic signed [31:0] shift_r2;
  } amv_in_t;

  // One request on the result channel: one row of the inverse.
  typedef struct packed {
    logic        [1:0]  row_number;
    logic signed [31:0] inv_c0;
    logic signed [31:0] inv_c1;
    logic signed [31:0] inv_c2;
    logic signed [31:0] inv_shift;
    logic               singular;
    logic               last;
  } amv_out_t;

endpackage

`default_nettype wire

// ----- rtl/amv_channels.sv -----
// Valid/ready channel interfaces for the matrix input and the row output.
// Depends on amv_pkg for the payload types.
`timescale 1ns / 1ps
`default_nettype none

interface amv_in_if;
  import amv_pkg::*;
  logic    valid;
  logic    ready;
  amv_in_t payload;
  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface

interface amv_out_if;
  import amv_pkg::*;
  logic     valid;
  logic     ready;
  amv_out_t payload;
  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- rtl/affine_matrix_inverse.sv -----
// Channel   | Dir | Payload                                   | Handshake
// in_chan   | in  | 3x4 affine matrix, twelve signed Q words  | valid/ready
// out_chan  | out | one inverse row, translation, flags       | valid/ready
//
// Each matrix yields three result rows, one per cycle unless the divider stalls;
// the row issuer ahead of the divider lanes takes a new matrix as it issues the
// last row of the one before. The path: 6 front stages, the issuer, 34 divider
// stages, the output register. Reset (synchronous, active low) clears the valid
// bits and the row counter. Every stage holds its data while the stage after it
// is full and stalled. Depends on amv_pkg and the interfaces in amv_channels.sv.
`timescale 1ns / 1ps
`default_nettype none

module affine_matrix_inverse #(
  parameter int FRAC_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  amv_in_if.sink    in_chan,
  amv_out_if.source out_chan
);
  import amv_pkg::*;

  localparam int PW = 97;                // m * cofactor
  localparam int SW = 99;                // sum of three products
  localparam int DW = SW;                // determinant magnitude
  localparam int NW = SW + FRAC_BITS;    // numerator magnitude
  localparam int QB = 33;                // quotient bits, top bit flags overflow
  localparam int XW = (NW > DW + QB) ? NW : DW + QB;

  typedef struct packed {
    logic [XW-1:0] rem;
    logic [QB-1:0] quo;
    logic          neg;
  } lane_t;

  typedef struct packed {
    logic [DW-1:0] den;
    logic [1:0]    row;
    logic          sing;
  } dctl_t;

  // ---------------- front end: one matrix per stage ----------------
  logic [6:1] vf_r;
  logic [7:1] en_f;
  logic       en_ser;

  logic signed [31:0] m_r [3][3];
  logic signed [31:0] t1_r [3];

  logic signed [63:0] pa_r [9], pa_nxt [9];
  logic signed [63:0] pb_r [9], pb_nxt [9];
  logic signed [31:0] m0_2_r [3], t2_r [3];

  logic signed [64:0] cof3_r [9];
  logic signed [31:0] m0_3_r [3], t3_r [3];

  logic signed [64:0] lo_r [12], lo_nxt [12];
  logic signed [64:0] hi_r [12], hi_nxt [12];
  logic signed [64:0] cof4_r [9];

  logic signed [PW-1:0] pr_r [12];
  logic signed [64:0]   cof5_r [9];

  logic signed [SW-1:0] det_r;
  logic signed [SW-1:0] dot_r [3];
  logic signed [64:0]   cof6_r [9];

  assign en_f[7] = en_ser;
  for (genvar k = 1; k <= 6; k++) begin : g_enf
    assign en_f[k] = !vf_r[k] || en_f[k+1];
  end
  assign in_chan.ready = en_f[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vf_r <= '0;
    end else begin
      if (en_f[1]) vf_r[1] <= in_chan.valid;
      for (int k = 2; k <= 6; k++) begin
        if (en_f[k]) vf_r[k] <= vf_r[k-1];
      end
    end
  end

  // Minor products for every cofactor.
  always_comb begin
    int r1, r2, c1, c2;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        r1 = (r == 0) ? 1 : 0;
        r2 = (r == 2) ? 1 : 2;
        c1 = (c == 0) ? 1 : 0;
        c2 = (c == 2) ? 1 : 2;
        pa_nxt[3*r+c] = m_r[r1][c1] * m_r[r2][c2];
        pb_nxt[3*r+c] = m_r[r1][c2] * m_r[r2][c1];
      end
    end
  end

  // The 32 x 65 products are split into two 32 x 33 partials.
  // Entries 0..2 feed the determinant, entry 3+3i+j is cof(j,i) * t_j.
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      lo_nxt[j] = m0_3_r[j] * $signed({1'b0, cof3_r[j][31:0]});
      hi_nxt[j] = m0_3_r[j] * $signed(cof3_r[j][64:32]);
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        lo_nxt[3+3*i+j] = t3_r[j] * $signed({1'b0, cof3_r[3*j+i][31:0]});
        hi_nxt[3+3*i+j] = t3_r[j] * $signed(cof3_r[3*j+i][64:32]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_f[1]) begin
      m_r[0][0] <= in_chan.payload.a_r0c0;
      m_r[0][1] <= in_chan.payload.a_r0c1;
      m_r[0][2] <= in_chan.payload.a_r0c2;
      m_r[1][0] <= in_chan.payload.a_r1c0;
      m_r[1][1] <= in_chan.payload.a_r1c1;
      m_r[1][2] <= in_chan.payload.a_r1c2;
      m_r[2][0] <= in_chan.payload.a_r2c0;
      m_r[2][1] <= in_chan.payload.a_r2c1;
      m_r[2][2] <= in_chan.payload.a_r2c2;
      t1_r[0]   <= in_chan.payload.shift_r0;
      t1_r[1]   <= in_chan.payload.shift_r1;
      t1_r[2]   <= in_chan.payload.shift_r2;
    end
    if (en_f[2]) begin
      pa_r   <= pa_nxt;
      pb_r   <= pb_nxt;
      m0_2_r <= m_r[0];
      t2_r   <= t1_r;
    end
    if (en_f[3]) begin
      for (int k = 0; k < 9; k++) begin
        // Odd positions carry the negated minor.
        cof3_r[k] <= ((k % 2) == 1) ? (pb_r[k] - pa_r[k]) : (pa_r[k] - pb_r[k]);
      end
      m0_3_r <= m0_2_r;
      t3_r   <= t2_r;
    end
    if (en_f[4]) begin
      lo_r   <= lo_nxt;
      hi_r   <= hi_nxt;
      cof4_r <= cof3_r;
    end
    if (en_f[5]) begin
      for (int k = 0; k < 12; k++) begin
        pr_r[k] <= $signed({hi_r[k], 32'b0}) + PW'(lo_r[k]);
      end
      cof5_r <= cof4_r;
    end
    if (en_f[6]) begin
      det_r <= SW'(pr_r[0]) + SW'(pr_r[1]) + SW'(pr_r[2]);
      for (int i = 0; i < 3; i++) begin
        dot_r[i] <= SW'(pr_r[3+3*i]) + SW'(pr_r[4+3*i]) + SW'(pr_r[5+3*i]);
      end
      cof6_r <= cof5_r;
    end
  end

  // ---------------- row issuer ----------------
  // Rows are held in a short shift line, so row 0 of the line is always issued.
  logic          sv_r;
  logic [1:0]    row_r;
  logic          ssing_r;
  logic          sdneg_r;
  logic [DW-1:0] sdmag_r;
  logic [63:0]   cmag_r [3][3];
  logic          cneg_r [3][3];
  logic [SW-1:0] tmag_r [3];
  logic          tneg_r [3];
  logic          en_d [0:QB+1];
  logic          issue;

  assign issue  = sv_r && en_d[0];
  assign en_ser = !sv_r || (issue && (row_r == ROW_LAST));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_r  <= 1'b0;
      row_r <= ROW_FIRST;
    end else if (en_ser) begin
      sv_r  <= vf_r[6];
      row_r <= ROW_FIRST;
    end else if (issue) begin
      row_r <= row_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (en_ser) begin
      ssing_r <= (det_r == '0);
      sdneg_r <= det_r[SW-1];
      sdmag_r <= det_r[SW-1] ? DW'(-det_r) : DW'(det_r);
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          // Row i of the inverse uses the cofactors of column i.
          cmag_r[i][j] <= cof6_r[3*j+i][64] ? 64'(-cof6_r[3*j+i]) : 64'(cof6_r[3*j+i]);
          cneg_r[i][j] <= cof6_r[3*j+i][64];
        end
        tmag_r[i] <= dot_r[i][SW-1] ? SW'(-dot_r[i]) : SW'(dot_r[i]);
        tneg_r[i] <= !dot_r[i][SW-1];
      end
    end else if (issue) begin
      cmag_r[0] <= cmag_r[1];
      cmag_r[1] <= cmag_r[2];
      cneg_r[0] <= cneg_r[1];
      cneg_r[1] <= cneg_r[2];
      tmag_r[0] <= tmag_r[1];
      tmag_r[1] <= tmag_r[2];
      tneg_r[0] <= tneg_r[1];
      tneg_r[1] <= tneg_r[2];
    end
  end

  // ---------------- divider lanes ----------------
  // Stage s of a lane settles quotient bit QB-s by one compare and subtract.
  logic  [QB:0] vd_r;
  lane_t ln_r   [0:QB][4];
  lane_t ln_nxt [0:QB][4];
  dctl_t dc_r   [0:QB];
  logic  en_out;
  logic  out_v_r;
  amv_out_t out_r, out_nxt;

  assign en_out      = !out_v_r || out_chan.ready;
  assign en_d[QB+1]  = en_out;
  for (genvar s = 0; s <= QB; s++) begin : g_end
    assign en_d[s] = !vd_r[s] || en_d[s+1];
  end

  always_comb begin
    logic [XW-1:0] sh;
    for (int j = 0; j < 3; j++) begin
      ln_nxt[0][j].rem = XW'(cmag_r[0][j]) << (2 * FRAC_BITS);
      ln_nxt[0][j].quo = '0;
      ln_nxt[0][j].neg = cneg_r[0][j] ^ sdneg_r;
    end
    ln_nxt[0][3].rem = XW'(tmag_r[0]) << FRAC_BITS;
    ln_nxt[0][3].quo = '0;
    ln_nxt[0][3].neg = tneg_r[0] ^ sdneg_r;
    for (int s = 1; s <= QB; s++) begin
      sh = XW'(dc_r[s-1].den) << (QB - s);
      for (int l = 0; l < 4; l++) begin
        ln_nxt[s][l].neg = ln_r[s-1][l].neg;
        if (ln_r[s-1][l].rem >= sh) begin
          ln_nxt[s][l].rem = ln_r[s-1][l].rem - sh;
          ln_nxt[s][l].quo = {ln_r[s-1][l].quo[QB-2:0], 1'b1};
        end else begin
          ln_nxt[s][l].rem = ln_r[s-1][l].rem;
          ln_nxt[s][l].quo = {ln_r[s-1][l].quo[QB-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r <= '0;
    end else begin
      if (en_d[0]) vd_r[0] <= sv_r;
      for (int s = 1; s <= QB; s++) begin
        if (en_d[s]) vd_r[s] <= vd_r[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_d[0]) begin
      ln_r[0]      <= ln_nxt[0];
      dc_r[0].den  <= sdmag_r;
      dc_r[0].row  <= row_r;
      dc_r[0].sing <= ssing_r;
    end
    for (int s = 1; s <= QB; s++) begin
      if (en_d[s]) begin
        ln_r[s] <= ln_nxt[s];
        dc_r[s] <= dc_r[s-1];
      end
    end
  end

  // Round to nearest, ties away from zero, then saturate and apply the sign.
  function automatic logic signed [31:0] finish(lane_t ln, logic [DW-1:0] den);
    logic [QB:0] q;
    logic        up;
    logic [31:0] res;
    up = ({ln.rem, 1'b0} >= (XW+1)'(den));
    q  = {1'b0, ln.quo} + (QB+1)'(up);
    if (ln.neg) begin
      if (q >= (QB+1)'(33'h080000000)) res = 32'h80000000;
      else res = 32'(-q[31:0]);
    end else begin
      if (q > (QB+1)'(33'h07FFFFFFF)) res = 32'h7FFFFFFF;
      else res = q[31:0];
    end
    return $signed(res);
  endfunction

  always_comb begin
    out_nxt.row_number = dc_r[QB].row;
    out_nxt.singular   = dc_r[QB].sing;
    out_nxt.last       = (dc_r[QB].row == ROW_LAST);
    if (dc_r[QB].sing) begin
      out_nxt.inv_c0    = '0;
      out_nxt.inv_c1    = '0;
      out_nxt.inv_c2    = '0;
      out_nxt.inv_shift = '0;
    end else begin
      out_nxt.inv_c0    = finish(ln_r[QB][0], dc_r[QB].den);
      out_nxt.inv_c1    = finish(ln_r[QB][1], dc_r[QB].den);
      out_nxt.inv_c2    = finish(ln_r[QB][2], dc_r[QB].den);
      out_nxt.inv_shift = finish(ln_r[QB][3], dc_r[QB].den);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en_out) begin
      out_v_r <= vd_r[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (en_out) out_r <= out_nxt;
  end

  assign out_chan.valid   = out_v_r;
  assign out_chan.payload = out_r;

endmodule

`default_nettype wire

// ----- rtl/amv_checker.sv -----
// Port-level checks for the affine matrix inverse, attached by bind.
// Depends on amv_pkg and the top level affine_matrix_inverse.
`timescale 1ns / 1ps
`default_nettype none

module amv_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire amv_pkg::amv_out_t out_payload
);
  import amv_pkg::*;

  logic [1:0] exp_row_r;
  logic       sing_r;

  // Track the row that the next request must carry and the flag of its matrix.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_row_r <= ROW_FIRST;
      sing_r    <= 1'b0;
    end else if (out_valid && out_ready) begin
      exp_row_r <= out_payload.last ? ROW_FIRST : exp_row_r + 2'd1;
      if (out_payload.row_number == ROW_FIRST) sing_r <= out_payload.singular;
    end
  end

  a_row_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_payload.row_number == exp_row_r)
    else $error("result rows out of order");

  a_last_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_payload.last == (out_payload.row_number == ROW_LAST))
    else $error("last flag does not match row 2");

  a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_payload.singular |->
      out_payload.inv_c0 == '0 && out_payload.inv_c1 == '0 &&
      out_payload.inv_c2 == '0 && out_payload.inv_shift == '0)
    else $error("singular result with nonzero entries");

  a_singular_same: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_payload.row_number != ROW_FIRST |-> out_payload.singular == sing_r)
    else $error("singular flag changed within one matrix");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_payload))
    else $error("stalled result changed");

endmodule

bind affine_matrix_inverse amv_checker u_amv_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .out_payload (out_chan.payload)
);

`default_nettype wire

// ----- dv/tb_affine_matrix_inverse.sv -----
// Testbench for affine_matrix_inverse: drives random and directed affine matrices
// and checks every inverse row against an exact wide-integer predictor.
// Depends on amv_pkg, amv_channels.sv and the block itself.
`timescale 1ns / 1ps
`default_nettype none

module tb_affine_matrix_inverse;
  import amv_pkg::*;

  localparam int FRAC = 16;
  localparam int N_RANDOM = 287;
  localparam int IDLE_LIMIT = 20000;

  typedef logic signed [255:0] wide_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #5 clk = ~clk;

  amv_in_if in_chan ();
  amv_out_if out_chan ();

  affine_matrix_inverse #(.FRAC_BITS(FRAC)) i_dut (
    .clk(clk), .rst_n(rst_n), .in_chan(in_chan.sink), .out_chan(out_chan.source)
  );

  // Rounded quotient, ties away from zero, saturated to 32 bits.
  function automatic logic signed [31:0] round_div(wide_t num, wide_t den);
    wide_t n, d, q, r;
    logic neg;
    neg = (num < 0) != (den < 0);
    n = (num < 0) ? -num : num;
    d = (den < 0) ? -den : den;
    q = n / d;
    r = n % d;
    if (2 * r >= d) q = q + 1;
    if (neg) q = -q;
    if (q > 64'sh7FFFFFFF) return 32'h7FFFFFFF;
    if (q < -64'sh80000000) return 32'h80000000;
    return q[31:0];
  endfunction

  class inverse_rows_sb;
    amv_out_t rows_due[$];
    int errors;
    int rows_checked;
    int singular_seen;

    function void note_matrix(amv_in_t m);
      wide_t a[3][3];
      wide_t t[3];
      wide_t cof[3][3];
      wide_t det, dot;
      amv_out_t row;
      int r1, r2, c1, c2;
      a[0][0] = m.a_r0c0; a[0][1] = m.a_r0c1; a[0][2] = m.a_r0c2; t[0] = m.shift_r0;
      a[1][0] = m.a_r1c0; a[1][1] = m.a_r1c1; a[1][2] = m.a_r1c2; t[1] = m.shift_r1;
      a[2][0] = m.a_r2c0; a[2][1] = m.a_r2c1; a[2][2] = m.a_r2c2; t[2] = m.shift_r2;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          r1 = (i == 0) ? 1 : 0; r2 = (i == 2) ? 1 : 2;
          c1 = (j == 0) ? 1 : 0; c2 = (j == 2) ? 1 : 2;
          cof[i][j] = a[r1][c1] * a[r2][c2] - a[r1][c2] * a[r2][c1];
          if ((i + j) % 2 == 1) cof[i][j] = -cof[i][j];
        end
      end
      det = a[0][0] * cof[0][0] + a[0][1] * cof[0][1] + a[0][2] * cof[0][2];
      if (det == 0) singular_seen++;
      for (int i = 0; i < 3; i++) begin
        row = '0;
        row.row_number = i[1:0];
        row.last = (i == 2);
        row.singular = (det == 0);
        if (det != 0) begin
          row.inv_c0 = round_div(cof[0][i] <<< (2 * FRAC), det);
          row.inv_c1 = round_div(cof[1][i] <<< (2 * FRAC), det);
          row.inv_c2 = round_div(cof[2][i] <<< (2 * FRAC), det);
          dot = cof[0][i] * t[0] + cof[1][i] * t[1] + cof[2][i] * t[2];
          row.inv_shift = round_div(-(dot <<< FRAC), det);
        end
        rows_due.push_back(row);
      end
    endfunction

    function void check_row(amv_out_t got);
      amv_out_t exp;
      if (rows_due.size() == 0) begin
        $error("unexpected row %0d", got.row_number);
        errors++;
        return;
      end
      exp = rows_due.pop_front();
      rows_checked++;
      if (got.row_number !== exp.row_number) begin
        $error("row_number exp %0d got %0d", exp.row_number, got.row_number); errors++;
      end
      if (got.inv_c0 !== exp.inv_c0) begin
        $error("inv_c0 exp %h got %h", exp.inv_c0, got.inv_c0); errors++;
      end
      if (got.inv_c1 !== exp.inv_c1) begin
        $error("inv_c1 exp %h got %h", exp.inv_c1, got.inv_c1); errors++;
      end
      if (got.inv_c2 !== exp.inv_c2) begin
        $error("inv_c2 exp %h got %h", exp.inv_c2, got.inv_c2); errors++;
      end
      if (got.inv_shift !== exp.inv_shift) begin
        $error("inv_shift exp %h got %h", exp.inv_shift, got.inv_shift); errors++;
      end
      if (got.singular !== exp.singular) begin
        $error("singular exp %b got %b", exp.singular, got.singular); errors++;
      end
      if (got.last !== exp.last) begin
        $error("last exp %b got %b", exp.last, got.last); errors++;
      end
    endfunction
  endclass

  inverse_rows_sb sb = new();
  int idle_cycles = 0;
  int sent = 0;
  bit hold_out = 1'b0;

  initial begin
    in_chan.valid = 1'b0;
    in_chan.payload = '0;
    out_chan.ready = 1'b0;
  end

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [31:0] rand_entry();
    case ($urandom_range(0, 7))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return 32'h00010000;
      3: return 32'hFFFF0000;
      4: return $urandom_range(0, 7) - 3;
      5: return {{12{1'b0}}, 20'($urandom)} - 32'h00080000;
      default: return $urandom;
    endcase
  endfunction

  // Half the kinds are well conditioned (near identity scale, modest translations), the rest use rand_entry.
  function automatic amv_in_t rand_matrix();
    amv_in_t m;
    int kind;
    kind = $urandom_range(0, 9);
    for (int k = 0; k < 12; k++) begin
      if (kind < 5) m[k*32 +: 32] = $signed(20'($urandom)) + (((k % 5) == 1) ? 32'sh10000 : 0);
      else m[k*32 +: 32] = rand_entry();
    end
    // Force a repeated row now and then so the determinant is zero.
    if (kind == 9) begin
      m.a_r2c0 = m.a_r0c0; m.a_r2c1 = m.a_r0c1; m.a_r2c2 = m.a_r0c2;
    end
    return m;
  endfunction

  task automatic send_matrix(amv_in_t m);
    in_chan.valid <= 1'b1;
    in_chan.payload <= m;
    do @(posedge clk); while (!in_chan.ready);
    sb.note_matrix(m);
    sent++;
  endtask

  task automatic send_with_gap(amv_in_t m);
    int g;
    send_matrix(m);
    g = pick_gap();
    if (g > 0) begin
      in_chan.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  function automatic amv_in_t diag(logic [31:0] d0, logic [31:0] d1, logic [31:0] d2);
    amv_in_t m;
    m = '0;
    m.a_r0c0 = d0; m.a_r1c1 = d1; m.a_r2c2 = d2;
    return m;
  endfunction

  task automatic directed_part();
    amv_in_t m;
    send_with_gap(diag(32'h10000, 32'h10000, 32'h10000));
    m = diag(32'h10000, 32'h10000, 32'h10000);
    m.shift_r0 = 32'h7FFFFFFF; m.shift_r1 = 32'h80000000; m.shift_r2 = 32'h00012345;
    send_with_gap(m);
    send_with_gap(diag(32'h20000, 32'hFFFE0000, 32'h8000));
    send_with_gap(diag(32'd1, 32'd1, 32'd1));                      // tiny: saturates
    send_with_gap(diag(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF));
    send_with_gap(diag(32'h80000000, 32'h80000000, 32'h80000000));
    send_with_gap('0);                                              // singular
    m = '1;
    send_with_gap(m);                                               // all -1 lsb: singular
    m = '0;
    m.a_r0c1 = 32'h10000; m.a_r1c2 = 32'h10000; m.a_r2c0 = 32'h10000;
    m.shift_r0 = 32'h30000; m.shift_r1 = 32'hFFFF8000; m.shift_r2 = 32'h1;
    send_with_gap(m);                                               // permutation
    // Exact quotients: determinant 2^48*2 over power-of-two cofactors.
    send_with_gap(diag(32'h20000, 32'h10000, 32'h10000));
    m = diag(32'd3, 32'd3, 32'd3);
    m.shift_r0 = 32'h1;
    send_with_gap(m);
    for (int k = 0; k < 12; k++) begin
      m = '0;
      m[k*32 +: 32] = (k % 2) ? 32'h80000000 : 32'h7FFFFFFF;
      m = m | diag(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
      send_with_gap(m);
    end
    in_chan.valid <= 1'b0;
  endtask

  // Receiver: random stalls, plus one long hold-off driven by hold_out.
  initial begin
    int g;
    @(posedge rst_n);
    forever begin
      if (hold_out) begin
        out_chan.ready <= 1'b0;
        @(posedge clk);
      end else begin
        g = pick_gap();
        if (g > 0) begin
          out_chan.ready <= 1'b0;
          repeat (g) @(posedge clk);
        end
        out_chan.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) sb.check_row(out_chan.payload);
  end

  // Watchdog on cycles with no request moving on either side.
  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout after %0d idle cycles", idle_cycles);
      $display("tb_affine_matrix_inverse failed");
      $finish;
    end
  end

  initial begin
    int waited;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    directed_part();
    for (int k = 0; k < N_RANDOM; k++) begin
      if (k == 100) begin
        hold_out <= 1'b1;
        fork
          begin
            repeat (300) @(posedge clk);
            hold_out <= 1'b0;
          end
        join_none
      end
      // A stretch with no input idling at all.
      if (k >= 200 && k < 240) send_matrix(rand_matrix());
      else send_with_gap(rand_matrix());
    end
    in_chan.valid <= 1'b0;
    waited = 0;
    while (sb.rows_due.size() != 0 && waited < IDLE_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (60) @(posedge clk);
    $display("Sent %0d matrices (%0d singular), checked %0d inverse rows.",
             sent, sb.singular_seen, sb.rows_checked);
    if (sb.errors == 0 && sb.rows_due.size() == 0) begin
      $display("tb_affine_matrix_inverse passed");
    end else begin
      $display("tb_affine_matrix_inverse failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
